// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Each check is clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define PTSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTSA_ASSERT_IMP(lbl, ante, cons, msg)
`define PTSA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/ptsa_pkg.sv =====
// Package for the page-table slot allocator: sizes, status codes and the
// structs passed between the sequencer, the probe unit and the block list RAM.
// No dependencies.
package ptsa_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int ADDR_BITS  = 36;

    localparam int BLK_SHIFT  = 16;
    localparam int SLOT_SHIFT = 12;
    localparam int SLOTS      = 16;
    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int BASE_W     = ADDR_BITS - BLK_SHIFT;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam logic [SLOTS-1:0] FULL_MASK = {SLOTS{1'b1}};

    // Stream widths: tdata packs two addresses rounded up to whole bytes.
    localparam int IN_TDATA_W   = ((2 * ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((2 * ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_TUSER_W  = 4;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
    localparam logic [1:0] ST_DOUBLE_FREE = 2'd2;
    localparam logic [1:0] ST_LIST_FULL   = 2'd3;

    typedef struct packed {
        logic [BASE_W-1:0] base;
        logic [SLOTS-1:0]  mask;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_t;

    typedef struct packed {
        logic              base_hit;
        logic              mask_empty;
        logic              slot_free;
        logic              full_after;
        logic              last;
        logic [SLOT_W-1:0] low_slot;
        logic [IDX_W-1:0]  idx_inc;
        logic [SLOTS-1:0]  claim_mask;
        logic [SLOTS-1:0]  rel_mask;
    } probe_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [ADDR_BITS-1:0] slot_addr;
        logic                 took_spare;
        logic                 block_freed;
        logic [ADDR_BITS-1:0] freed_base;
    } result_t;

endpackage

// ===== rtl/ptsa_table.sv =====
// Block list storage: one entry per block holding its base and free mask.
// One write port and one read port with registered read data. Uses ptsa_pkg.
module ptsa_table
(
    input  logic                        clk,
    input  logic [ptsa_pkg::IDX_W-1:0]  rd_addr,
    input  ptsa_pkg::wr_t               wr,
    output ptsa_pkg::entry_t            rd_data
);

    ptsa_pkg::entry_t mem [ptsa_pkg::MAX_BLOCKS];
    ptsa_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/ptsa_probe.sv =====
// Shared probe unit: evaluates one block list entry per cycle for the sequencer.
// Base compare, slot tests, lowest free slot, new masks and end-of-list test.
// Uses ptsa_pkg.
module ptsa_probe
(
    input  ptsa_pkg::entry_t                   entry,
    input  logic [ptsa_pkg::BASE_W-1:0]        key,
    input  logic [ptsa_pkg::SLOT_W-1:0]        slot,
    input  logic [ptsa_pkg::IDX_W-1:0]         idx,
    input  logic [ptsa_pkg::CNT_W-1:0]         count,
    output ptsa_pkg::probe_t                   probe
);

    logic [ptsa_pkg::SLOT_W-1:0] low;
    logic [ptsa_pkg::SLOTS-1:0]  slot_bit;
    logic [ptsa_pkg::SLOTS-1:0]  low_bit;
    logic [ptsa_pkg::SLOTS-1:0]  rel;

    always_comb
    begin
        low = '0;
        for (int i = ptsa_pkg::SLOTS - 1; i >= 0; i--)
        begin
            if (entry.mask[i])
            begin
                low = ptsa_pkg::SLOT_W'(i);
            end
        end
    end

    assign slot_bit = ptsa_pkg::SLOTS'(1) << slot;
    assign low_bit  = ptsa_pkg::SLOTS'(1) << low;
    assign rel      = entry.mask | slot_bit;

    assign probe.base_hit   = (entry.base == key);
    assign probe.mask_empty = (entry.mask == '0);
    assign probe.slot_free  = ((entry.mask & slot_bit) != '0);
    assign probe.full_after = (rel == ptsa_pkg::FULL_MASK);
    // The entry is the last one in the list when idx + 1 reaches the count.
    assign probe.last       = (ptsa_pkg::CNT_W'(idx) + ptsa_pkg::CNT_W'(1)) >= count;
    assign probe.low_slot   = low;
    assign probe.idx_inc    = idx + ptsa_pkg::IDX_W'(1);
    assign probe.claim_mask = entry.mask & ~low_bit;
    assign probe.rel_mask   = rel;

endmodule

// ===== rtl/ptsa_seq.sv =====
// Sequencer of the allocator: walks the block list one entry per cycle through
// the shared probe unit, claims or releases slots and compacts the list.
// Uses ptsa_pkg, ptsa_probe and assert_macros.svh.
`include "assert_macros.svh"

module ptsa_seq
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic                              op,
    input  logic [ptsa_pkg::ADDR_BITS-1:0]    release_addr,
    input  logic [ptsa_pkg::ADDR_BITS-1:0]    spare_block,
    output logic                              result_valid,
    input  logic                              result_ready,
    output ptsa_pkg::result_t                 result,
    output logic [ptsa_pkg::IDX_W-1:0]        rd_addr,
    input  ptsa_pkg::entry_t                  rd_data,
    output ptsa_pkg::wr_t                     wr
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_A_CHK = 3'd1;
    localparam logic [2:0] S_A_NEW = 3'd2;
    localparam logic [2:0] S_R_CHK = 3'd3;
    localparam logic [2:0] S_R_SH  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [ptsa_pkg::CNT_W-1:0]    cur_reg, cur_next;
    logic [ptsa_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [ptsa_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [ptsa_pkg::BASE_W-1:0]   key_reg, key_next;
    logic [ptsa_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [ptsa_pkg::BASE_W-1:0]   spare_reg, spare_next;
    ptsa_pkg::result_t             res_reg, res_next;
    ptsa_pkg::probe_t              probe;
    logic                          remove;
    logic [ptsa_pkg::CNT_W-1:0]    cnt_dec;

    ptsa_probe u_probe
    (
        .entry (rd_data),
        .key   (key_reg),
        .slot  (slot_reg),
        .idx   (idx_reg),
        .count (cnt_reg),
        .probe (probe)
    );

    assign cnt_dec = cnt_reg - ptsa_pkg::CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        key_next   = key_reg;
        slot_next  = slot_reg;
        spare_next = spare_reg;
        res_next   = res_reg;
        wr         = '0;
        remove     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    res_next = '0;
                    if (op == ptsa_pkg::OP_RELEASE)
                    begin
                        key_next  = release_addr[ptsa_pkg::ADDR_BITS-1:ptsa_pkg::BLK_SHIFT];
                        slot_next = release_addr[ptsa_pkg::SLOT_SHIFT+ptsa_pkg::SLOT_W-1:
                                                 ptsa_pkg::SLOT_SHIFT];
                        idx_next  = '0;
                        if (cnt_reg == '0)
                        begin
                            res_next.status = ptsa_pkg::ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_R_CHK;
                        end
                    end
                    else
                    begin
                        spare_next = spare_block[ptsa_pkg::ADDR_BITS-1:ptsa_pkg::BLK_SHIFT];
                        idx_next   = cur_reg[ptsa_pkg::IDX_W-1:0];
                        state_next = (cur_reg < cnt_reg) ? S_A_CHK : S_A_NEW;
                    end
                end
            end

            S_A_CHK:
            begin
                if (!probe.mask_empty)
                begin
                    wr.en              = 1'b1;
                    wr.addr            = idx_reg;
                    wr.data.base       = rd_data.base;
                    wr.data.mask       = probe.claim_mask;
                    res_next.slot_addr = {rd_data.base, probe.low_slot,
                                          {ptsa_pkg::SLOT_SHIFT{1'b0}}};
                    state_next         = S_DONE;
                end
                else if (!probe.last)
                begin
                    cur_next = cur_reg + ptsa_pkg::CNT_W'(1);
                    idx_next = probe.idx_inc;
                end
                else
                begin
                    cur_next   = cnt_reg;
                    state_next = S_A_NEW;
                end
            end

            S_A_NEW:
            begin
                if (cnt_reg == ptsa_pkg::CNT_W'(ptsa_pkg::MAX_BLOCKS))
                begin
                    res_next.status = ptsa_pkg::ST_LIST_FULL;
                end
                else
                begin
                    // Adopt the spare block and hand out its slot zero at once.
                    wr.en               = 1'b1;
                    wr.addr             = cnt_reg[ptsa_pkg::IDX_W-1:0];
                    wr.data.base        = spare_reg;
                    wr.data.mask        = ptsa_pkg::FULL_MASK & ~ptsa_pkg::SLOTS'(1);
                    cur_next            = cnt_reg;
                    cnt_next            = cnt_reg + ptsa_pkg::CNT_W'(1);
                    res_next.slot_addr  = {spare_reg, {ptsa_pkg::BLK_SHIFT{1'b0}}};
                    res_next.took_spare = 1'b1;
                end
                state_next = S_DONE;
            end

            S_R_CHK:
            begin
                if (probe.base_hit)
                begin
                    if (probe.slot_free)
                    begin
                        res_next.status = ptsa_pkg::ST_DOUBLE_FREE;
                        state_next      = S_DONE;
                    end
                    else if (!probe.full_after)
                    begin
                        wr.en        = 1'b1;
                        wr.addr      = idx_reg;
                        wr.data.base = rd_data.base;
                        wr.data.mask = probe.rel_mask;
                        state_next   = S_DONE;
                    end
                    else if (!probe.last)
                    begin
                        idx_next   = probe.idx_inc;
                        state_next = S_R_SH;
                    end
                    else
                    begin
                        remove = 1'b1;
                    end
                end
                else if (!probe.last)
                begin
                    idx_next = probe.idx_inc;
                end
                else
                begin
                    res_next.status = ptsa_pkg::ST_NOT_FOUND;
                    state_next      = S_DONE;
                end
            end

            S_R_SH:
            begin
                // The entry read here moves down over the one before it.
                wr.en   = 1'b1;
                wr.addr = idx_reg - ptsa_pkg::IDX_W'(1);
                wr.data = rd_data;
                if (!probe.last)
                begin
                    idx_next = probe.idx_inc;
                end
                else
                begin
                    remove = 1'b1;
                end
            end

            S_DONE:
            begin
                if (result_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (remove)
        begin
            cnt_next             = cnt_dec;
            cur_next             = (cur_reg > cnt_dec) ? cnt_dec : cur_reg;
            res_next.block_freed = 1'b1;
            res_next.freed_base  = {key_reg, {ptsa_pkg::BLK_SHIFT{1'b0}}};
            state_next           = S_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        slot_reg  <= slot_next;
        spare_reg <= spare_next;
        res_reg   <= res_next;
    end

    // The RAM samples the next index so that its data lines up with idx_reg.
    assign rd_addr      = idx_next;
    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_DONE);
    assign result       = res_reg;

    `PTSA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= ptsa_pkg::CNT_W'(ptsa_pkg::MAX_BLOCKS),
        "block count beyond list size")
    `PTSA_ASSERT_IMP(a_cur_le_cnt, 1'b1, cur_reg <= cnt_reg, "scan cursor beyond block count")
    `PTSA_ASSERT_IMP(a_wr_in_list, wr.en, ptsa_pkg::CNT_W'(wr.addr) <= cnt_reg,
        "list write above the end of the list")
    `PTSA_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready,
        "sequencer stayed idle after taking a word")

endmodule

// ===== rtl/page_table_slot_allocator.sv =====
// Page-table slot allocator: usage notes.
// Slave stream (s_*) carries one request word: s_tuser holds op (0 allocate,
// 1 release); s_tdata holds release_addr then spare_block. Master stream (m_*)
// returns exactly one result word per request: m_tuser holds status, took_spare
// and block_freed; m_tdata holds slot_addr then freed_base.
// An allocation reads the list entry at the cursor and scans on until a block
// with a free slot is found; past the end of the list it adopts the spare
// block if the list has room. A release probes one entry per cycle to find
// its block and, when the block leaves the list, moves each later entry down
// one place. The block list RAM has a single read port, whose data feeds one
// shared probe unit. s_tready is high only while no request is in progress.
// The output register lets the next request be taken while a result waits;
// a stalled m_tready holds the result, and the following request finishes its
// work and then waits until the output register is free.
// Reset empties the list and clears the cursor; the RAM itself is not cleared.
// Uses ptsa_pkg, ptsa_table and ptsa_seq.
module page_table_slot_allocator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [ptsa_pkg::IN_TDATA_W-1:0]      s_tdata,  // release_addr, spare_block
    input  logic                                 s_tuser,  // op
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [ptsa_pkg::OUT_TDATA_W-1:0]     m_tdata,  // slot_addr, freed_base
    output logic [ptsa_pkg::OUT_TUSER_W-1:0]     m_tuser   // status, took_spare, block_freed
);

    logic [ptsa_pkg::IDX_W-1:0] rd_addr;
    ptsa_pkg::entry_t           rd_data;
    ptsa_pkg::wr_t              wr;
    ptsa_pkg::result_t          result;
    logic                       result_valid;
    logic                       result_ready;
    logic                       m_valid_reg, m_valid_next;
    ptsa_pkg::result_t          m_res_reg;
    logic [ptsa_pkg::OUT_TDATA_W-1:0] m_data;

    ptsa_table u_table
    (
        .clk     (clk),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_data (rd_data)
    );

    ptsa_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (s_tvalid),
        .item_ready   (s_tready),
        .op           (s_tuser),
        .release_addr (s_tdata[ptsa_pkg::ADDR_BITS-1:0]),
        .spare_block  (s_tdata[2*ptsa_pkg::ADDR_BITS-1:ptsa_pkg::ADDR_BITS]),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr           (wr)
    );

    assign result_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (result_valid && result_ready)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid && result_ready)
        begin
            m_res_reg <= result;
        end
    end

    always_comb
    begin
        m_data = '0;
        m_data[2*ptsa_pkg::ADDR_BITS-1:0] = {m_res_reg.freed_base, m_res_reg.slot_addr};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data;
    assign m_tuser  = {m_res_reg.block_freed, m_res_reg.took_spare, m_res_reg.status};

endmodule

// ===== test/ptsa_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the page-table slot allocator: keeps its own block list,
// predicts the result word of every accepted request and compares on arrival.
// Depends on ptsa_pkg.
module ptsa_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    input  logic                                 s_tready,
    input  logic [ptsa_pkg::IN_TDATA_W-1:0]      s_tdata,  // release_addr, spare_block
    input  logic                                 s_tuser,  // op
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [ptsa_pkg::OUT_TDATA_W-1:0]     m_tdata,  // slot_addr, freed_base
    input  logic [ptsa_pkg::OUT_TUSER_W-1:0]     m_tuser,  // status, took_spare, block_freed
    output int                                   errors,
    output int                                   pending,
    output logic                                 granted,
    output logic [ptsa_pkg::ADDR_BITS-1:0]       granted_addr
);
    import ptsa_pkg::*;

    logic [BASE_W-1:0] blk_base [MAX_BLOCKS];
    logic [SLOTS-1:0]  blk_free [MAX_BLOCKS];
    int                cursor;
    int                live_blocks;
    result_t           expected_q[$];

    task automatic report_mismatch(input string what, input logic [ADDR_BITS-1:0] got,
                                   input logic [ADDR_BITS-1:0] want);
        errors++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic compare_field(input string what, input logic [ADDR_BITS-1:0] got,
                                 input logic [ADDR_BITS-1:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Applies one request to the block list and returns the result it must produce.
    function automatic result_t serve_request(input logic op,
                                              input logic [ADDR_BITS-1:0] rel_addr,
                                              input logic [ADDR_BITS-1:0] spare);
        result_t           r;
        logic [BASE_W-1:0] base;
        logic [SLOT_W-1:0] slot;
        int                idx;
        r = '0;
        r.status = ST_OK;
        if (op == OP_ALLOC)
        begin
            while (cursor < live_blocks && blk_free[cursor] == '0)
                cursor++;
            if (cursor >= live_blocks)
            begin
                if (live_blocks >= MAX_BLOCKS)
                begin
                    r.status = ST_LIST_FULL;
                    return r;
                end
                blk_base[live_blocks] = spare[ADDR_BITS-1:BLK_SHIFT];
                blk_free[live_blocks] = FULL_MASK;
                cursor = live_blocks;
                live_blocks++;
                r.took_spare = 1'b1;
            end
            slot = '0;
            for (int i = SLOTS - 1; i >= 0; i--)
                if (blk_free[cursor][i])
                    slot = SLOT_W'(i);
            blk_free[cursor][slot] = 1'b0;
            r.slot_addr = {blk_base[cursor], slot, {SLOT_SHIFT{1'b0}}};
            return r;
        end
        base = rel_addr[ADDR_BITS-1:BLK_SHIFT];
        slot = rel_addr[BLK_SHIFT-1:SLOT_SHIFT];
        // The first listed block with a matching base wins.
        idx = -1;
        for (int j = live_blocks - 1; j >= 0; j--)
            if (blk_base[j] == base)
                idx = j;
        if (idx < 0)
        begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        if (blk_free[idx][slot])
        begin
            r.status = ST_DOUBLE_FREE;
            return r;
        end
        blk_free[idx][slot] = 1'b1;
        if (blk_free[idx] == FULL_MASK)
        begin
            for (int j = idx; j < live_blocks - 1; j++)
            begin
                blk_base[j] = blk_base[j + 1];
                blk_free[j] = blk_free[j + 1];
            end
            live_blocks--;
            if (cursor > live_blocks)
                cursor = live_blocks;
            r.block_freed = 1'b1;
            r.freed_base = {base, {BLK_SHIFT{1'b0}}};
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t              want;
        logic                 grant_now;
        logic [ADDR_BITS-1:0] grant_addr_now;
        if (!rst_n)
        begin
            cursor = 0;
            live_blocks = 0;
            expected_q.delete();
            granted <= 1'b0;
            granted_addr <= '0;
            pending <= 0;
        end
        else
        begin
            grant_now = 1'b0;
            grant_addr_now = granted_addr;
            // Results are checked before the new request is queued, so a word
            // arriving on the same edge is matched against older requests only.
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result word with nothing outstanding",
                                    m_tdata[ADDR_BITS-1:0], '0);
                else
                begin
                    want = expected_q.pop_front();
                    compare_field("status", ADDR_BITS'(m_tuser[1:0]),
                                  ADDR_BITS'(want.status));
                    compare_field("slot_addr", m_tdata[ADDR_BITS-1:0], want.slot_addr);
                    compare_field("took_spare", ADDR_BITS'(m_tuser[2]),
                                  ADDR_BITS'(want.took_spare));
                    compare_field("block_freed", ADDR_BITS'(m_tuser[3]),
                                  ADDR_BITS'(want.block_freed));
                    compare_field("freed_base", m_tdata[2*ADDR_BITS-1:ADDR_BITS],
                                  want.freed_base);
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = serve_request(s_tuser, s_tdata[ADDR_BITS-1:0],
                                     s_tdata[2*ADDR_BITS-1:ADDR_BITS]);
                expected_q.push_back(want);
                if (s_tuser == OP_ALLOC && want.status == ST_OK)
                begin
                    grant_now = 1'b1;
                    grant_addr_now = want.slot_addr;
                end
            end
            granted <= grant_now;
            granted_addr <= grant_addr_now;
            pending <= expected_q.size();
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the page-table slot allocator testbench: clock, reset, request and
// result stream traffic, watchdog and verdict. Uses ptsa_pkg and ptsa_checker.
module testbench;
    import ptsa_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * MAX_BLOCKS + 40;
    localparam int HOLD_CYCLES  = 600;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;   // release_addr, spare_block
    logic                   s_tuser = 1'b0; // op
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;        // slot_addr, freed_base
    logic [OUT_TUSER_W-1:0] m_tuser;        // status, took_spare, block_freed

    int                     errors;
    int                     pending;
    logic                   granted;
    logic [ADDR_BITS-1:0]   granted_addr;

    logic [ADDR_BITS-1:0]   live_slots[$];
    logic [ADDR_BITS-1:0]   freed_slots[$];
    int                     words_in = 0;
    int                     full_seen = 0;
    int                     idle_cycles = 0;
    int                     burst_left = 0;

    page_table_slot_allocator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ptsa_checker result_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .pending      (pending),
        .granted      (granted),
        .granted_addr (granted_addr)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Granted slots are collected away from the driving edge.
    always @(negedge clk)
        if (granted)
            live_slots.push_back(granted_addr);

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            words_in <= words_in + 1;
        if (m_tvalid && m_tready && m_tuser[1:0] == ST_LIST_FULL)
            full_seen <= full_seen + 1;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [ADDR_BITS-1:0] rand_addr();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[ADDR_BITS-1:0];
    endfunction

    // Offers one request word and returns on the edge that accepts it.
    task automatic send_word(input logic op, input logic [ADDR_BITS-1:0] rel_addr,
                             input logic [ADDR_BITS-1:0] spare);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {spare, rel_addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    // Allocates in alloc_pct percent of calls, else mostly releases of slots handed
    // out earlier, newest first half the time, with stray and repeated releases.
    task automatic random_item(input int alloc_pct);
        int                   pick;
        logic [ADDR_BITS-1:0] addr;
        logic [ADDR_BITS-1:0] spare;
        spare = rand_addr();
        if ($urandom_range(0, 4) != 0)
            spare[BLK_SHIFT-1:0] = '0;
        addr = rand_addr();
        if ($urandom_range(0, 99) < alloc_pct)
        begin
            send_word(OP_ALLOC, addr, spare);
            return;
        end
        pick = $urandom_range(0, 19);
        if (pick == 1 && freed_slots.size() != 0)
            addr = freed_slots[$urandom_range(0, freed_slots.size() - 1)];
        else if (pick != 0 && live_slots.size() != 0)
        begin
            pick = ($urandom_range(0, 1) == 0) ? live_slots.size() - 1
                                               : $urandom_range(0, live_slots.size() - 1);
            addr = {live_slots[pick][ADDR_BITS-1:SLOT_SHIFT], addr[SLOT_SHIFT-1:0]};
            freed_slots.push_back(live_slots[pick]);
            live_slots.delete(pick);
            if (freed_slots.size() > 32)
                void'(freed_slots.pop_front());
        end
        send_word(OP_RELEASE, addr, spare);
    endtask

    // Result side: stall patterns of random length, plus one long hold-off
    // that lets the block fill up and stop taking requests.
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && words_in >= 250)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 200);
                repeat (span)
                begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= $urandom_range(0, 1);
                        2: m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= ~m_tready;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int done;
        int seg;
        int pct;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Releases on an empty list, then one block taken from an unaligned
        // spare, a slot freed twice, and the block leaving the list.
        send_word(OP_RELEASE, '0, '0);
        send_word(OP_RELEASE, '1, '1);
        send_word(OP_ALLOC, '0, '1);
        send_word(OP_ALLOC, '1, '0);
        send_word(OP_RELEASE, {{BASE_W{1'b1}}, 4'h0, 12'hFFF}, '0);
        send_word(OP_RELEASE, {{BASE_W{1'b1}}, 4'h0, 12'h000}, '0);
        send_word(OP_RELEASE, {{BASE_W{1'b1}}, 4'h1, 12'hABC}, '1);
        // Base zero, a stray release, then fill base zero and spill into a new block.
        send_word(OP_ALLOC, '1, {{BASE_W{1'b0}}, 16'hFFFF});
        send_word(OP_RELEASE, {{(BASE_W-1){1'b0}}, 1'b1, 16'h0000}, '0);
        repeat (SLOTS) send_word(OP_ALLOC, rand_addr(),
                                 ADDR_BITS'({rand_addr() >> BLK_SHIFT, 16'h0}));

        done = 0;
        while (done < 200)
        begin
            seg = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0: pct = 15;
                1: pct = 50;
                default: pct = 85;
            endcase
            repeat (seg) random_item(pct);
            done += seg;
        end

        // Fill the list until allocations keep coming back with the list full.
        done = 0;
        while (full_seen < 6 && done < 1400)
        begin
            random_item(95);
            done++;
        end

        repeat (150) random_item(15);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
